FILE: rtl/s2l_pkg.sv
// ----------------------------------------------------------------------------
// s2l_pkg
// Shared types, constants and the gamma expansion table for the sRGB to
// CIELAB converter.
// ----------------------------------------------------------------------------
`default_nettype none

package s2l_pkg;

    localparam int OUT_FRAC_BITS = 8;
    localparam int RND_SH        = 16 - OUT_FRAC_BITS;

    localparam int LIN_W = 17;   // Q16 linear light, 0..65536
    localparam int SUM_W = 30;   // matrix row sums
    localparam int X10_W = 33;   // ten times a row sum
    localparam int V_W   = 17;   // normalized tristimulus, Q16
    localparam int F_W   = 17;   // curve output, Q16
    localparam int AC_W  = 28;   // L, a, b before rounding

    // pipeline depth of each part
    localparam int XYZ_STG = 5;
    localparam int CRV_STG = 19;
    localparam int OUT_STG = 2;
    localparam int TOT_STG = XYZ_STG + CRV_STG + OUT_STG;

    // sRGB to XYZ matrix, scaled by 10000
    localparam logic [13:0] M_XR = 14'd4124;
    localparam logic [13:0] M_XG = 14'd3576;
    localparam logic [13:0] M_XB = 14'd1805;
    localparam logic [13:0] M_YR = 14'd2126;
    localparam logic [13:0] M_YG = 14'd7152;
    localparam logic [13:0] M_YB = 14'd722;
    localparam logic [13:0] M_ZR = 14'd193;
    localparam logic [13:0] M_ZG = 14'd1192;
    localparam logic [13:0] M_ZB = 14'd9505;

    // white point divisors and their floor reciprocals
    localparam logic [16:0] DIV_X = 17'd95047;
    localparam logic [13:0] DIV_Y = 14'd10000;
    localparam logic [16:0] DIV_Z = 17'd108883;
    localparam int          SH_XZ = 33;
    localparam int          SH_Y  = 31;
    localparam logic [16:0] RCP_X = 17'((64'd1 << SH_XZ) / 64'd95047);
    localparam logic [17:0] RCP_Y = 18'((64'd1 << SH_Y) / 64'd10000);
    localparam logic [16:0] RCP_Z = 17'((64'd1 << SH_XZ) / 64'd108883);

    // curve: linear segment at or below the threshold, reciprocal of 1000 rounded up
    localparam logic [V_W-1:0] CUBE_MIN = V_W'((64'd8856 * 64'd65536) / 64'd1000000);
    localparam logic [12:0]    LIN_SLOPE = 13'd7787;
    localparam int             SH_K = 33;
    localparam logic [23:0]    RCP_K = 24'(((64'd1 << SH_K) + 64'd999) / 64'd1000);
    localparam logic [F_W-1:0] LIN_OFS = F_W'(9039);

    localparam logic signed [AC_W-1:0] L_MUL = AC_W'(116);
    localparam logic signed [AC_W-1:0] L_OFS = AC_W'(16 * 65536);
    localparam logic signed [AC_W-1:0] A_MUL = AC_W'(500);
    localparam logic signed [AC_W-1:0] B_MUL = AC_W'(200);
    localparam logic signed [AC_W-1:0] RND_HALF = AC_W'(1) <<< (RND_SH - 1);

    typedef logic [255:0][LIN_W-1:0] t_lin_tab;

    // gamma expansion of every code, evaluated at elaboration only
    function automatic t_lin_tab build_lin_tab();
        t_lin_tab tab;
        longint unsigned c;
        longint unsigned t;
        longint unsigned t2;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned lin;
        for (int i = 0; i < 256; i++) begin
            c = longint'(i);
            if (c * 100000 <= 4045 * 255) begin
                lin = (c * 655360) / 32946;
            end else begin
                t  = ((1000 * c + 14025) * 65536) / 269025;
                t2 = (t * t) >> 16;
                lo = 0;
                hi = 4096;
                while (lo < hi) begin
                    mid = (lo + hi + 1) >> 1;
                    if (mid * mid * mid * mid * mid <= (t2 << 44)) lo = mid;
                    else hi = mid - 1;
                end
                lin = (t2 * lo) >> 12;
            end
            tab[i] = LIN_W'(lin);
        end
        return tab;
    endfunction

    localparam t_lin_tab LIN_TAB = build_lin_tab();

endpackage

`default_nettype wire

FILE: rtl/srgb_to_cielab_top.sv
// ----------------------------------------------------------------------------
// srgb_to_cielab_top
// sRGB pixel to CIELAB L, a, b (D65 white), fully pipelined.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle while the output is not stalled; the cube
// root pipeline (one bit a stage) sets the depth.
// A stall at the output holds the whole pipeline in place.
// Reset clears the valid bits only; data registers are not reset.
`default_nettype none

module srgb_to_cielab_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire logic [7:0]   i_red,
    input  wire logic [7:0]   i_green,
    input  wire logic [7:0]   i_blue,
    output logic              o_valid,
    input  wire logic         i_stall,
    output logic [14:0]       o_lightness,
    output logic [15:0]       o_green_red,
    output logic [15:0]       o_blue_yellow
);

    localparam int NS = s2l_pkg::TOT_STG;
    localparam int AW = s2l_pkg::AC_W;
    localparam int FW = s2l_pkg::F_W;

    logic                en;
    logic [NS-1:0]       r_vld;
    logic [FW-1:0]       x, y, z, fx, fy, fz;

    logic signed [AW-1:0] r_l1, r_a1, r_b1;
    logic signed [AW-1:0] n_dxy, n_dyz, n_lr, n_ar, n_br;
    logic [14:0]          r_l;
    logic [15:0]          r_a, r_b;

    // advance everything unless the output is held
    assign en      = !(r_vld[NS-1] && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    s2l_xyz u_xyz (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_red   (i_red),
        .i_green (i_green),
        .i_blue  (i_blue),
        .o_x     (x),
        .o_y     (y),
        .o_z     (z)
    );

    s2l_curve u_crv_x (.i_clk(i_clk), .i_en(en), .i_v(x), .o_f(fx));
    s2l_curve u_crv_y (.i_clk(i_clk), .i_en(en), .i_v(y), .o_f(fy));
    s2l_curve u_crv_z (.i_clk(i_clk), .i_en(en), .i_v(z), .o_f(fz));

    always_comb begin
        n_dxy = AW'($signed({1'b0, fx}) - $signed({1'b0, fy}));
        n_dyz = AW'($signed({1'b0, fy}) - $signed({1'b0, fz}));
        n_lr  = (r_l1 + s2l_pkg::RND_HALF) >>> s2l_pkg::RND_SH;
        n_ar  = (r_a1 + s2l_pkg::RND_HALF) >>> s2l_pkg::RND_SH;
        n_br  = (r_b1 + s2l_pkg::RND_HALF) >>> s2l_pkg::RND_SH;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_l1 <= $signed(AW'(fy)) * s2l_pkg::L_MUL - s2l_pkg::L_OFS;
            r_a1 <= n_dxy * s2l_pkg::A_MUL;
            r_b1 <= n_dyz * s2l_pkg::B_MUL;

            if (n_lr < 0)                 r_l <= '0;
            else if (n_lr > AW'(32767))   r_l <= 15'h7fff;
            else                          r_l <= n_lr[14:0];

            if (n_ar < -AW'(32768))       r_a <= 16'h8000;
            else if (n_ar > AW'(32767))   r_a <= 16'h7fff;
            else                          r_a <= n_ar[15:0];

            if (n_br < -AW'(32768))       r_b <= 16'h8000;
            else if (n_br > AW'(32767))   r_b <= 16'h7fff;
            else                          r_b <= n_br[15:0];
        end
    end

    assign o_valid       = r_vld[NS-1];
    assign o_lightness   = r_l;
    assign o_green_red   = r_a;
    assign o_blue_yellow = r_b;

endmodule

`default_nettype wire

FILE: rtl/s2l_xyz.sv
// ----------------------------------------------------------------------------
// s2l_xyz
// Gamma expansion, matrix to XYZ and white point normalization, five stages.
// ----------------------------------------------------------------------------
`default_nettype none

module s2l_xyz (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic [7:0]                i_red,
    input  wire logic [7:0]                i_green,
    input  wire logic [7:0]                i_blue,
    output logic [s2l_pkg::V_W-1:0]        o_x,
    output logic [s2l_pkg::V_W-1:0]        o_y,
    output logic [s2l_pkg::V_W-1:0]        o_z
);

    localparam int LW = s2l_pkg::LIN_W;
    localparam int SW = s2l_pkg::SUM_W;
    localparam int XW = s2l_pkg::X10_W;
    localparam int VW = s2l_pkg::V_W;

    logic [LW-1:0] r_lr, r_lg, r_lb;
    logic [30:0]   r_pxr, r_pxg, r_pxb, r_pyr, r_pyg, r_pyb, r_pzr, r_pzg, r_pzb;
    logic [SW-1:0] r_sx, r_sy, r_sz;
    logic [XW-1:0] r_xx, r_xz;
    logic [SW-1:0] r_xy;
    logic [VW-1:0] r_qx, r_qy, r_qz;
    logic [VW-1:0] r_x, r_y, r_z;

    logic [49:0] n_px, n_pz;
    logic [47:0] n_py;
    logic [33:0] n_rx, n_rz;
    logic [31:0] n_ry;

    always_comb begin
        n_px = 50'(XW'(r_sx) * 4'd10) * 50'(s2l_pkg::RCP_X);
        n_pz = 50'(XW'(r_sz) * 4'd10) * 50'(s2l_pkg::RCP_Z);
        n_py = 48'(r_sy) * 48'(s2l_pkg::RCP_Y);
        n_rx = 34'(r_xx) - 34'(r_qx) * 34'(s2l_pkg::DIV_X);
        n_rz = 34'(r_xz) - 34'(r_qz) * 34'(s2l_pkg::DIV_Z);
        n_ry = 32'(r_xy) - 32'(r_qy) * 32'(s2l_pkg::DIV_Y);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lr <= s2l_pkg::LIN_TAB[i_red];
            r_lg <= s2l_pkg::LIN_TAB[i_green];
            r_lb <= s2l_pkg::LIN_TAB[i_blue];

            r_pxr <= 31'(r_lr) * 31'(s2l_pkg::M_XR);
            r_pxg <= 31'(r_lg) * 31'(s2l_pkg::M_XG);
            r_pxb <= 31'(r_lb) * 31'(s2l_pkg::M_XB);
            r_pyr <= 31'(r_lr) * 31'(s2l_pkg::M_YR);
            r_pyg <= 31'(r_lg) * 31'(s2l_pkg::M_YG);
            r_pyb <= 31'(r_lb) * 31'(s2l_pkg::M_YB);
            r_pzr <= 31'(r_lr) * 31'(s2l_pkg::M_ZR);
            r_pzg <= 31'(r_lg) * 31'(s2l_pkg::M_ZG);
            r_pzb <= 31'(r_lb) * 31'(s2l_pkg::M_ZB);

            r_sx <= SW'(32'(r_pxr) + 32'(r_pxg) + 32'(r_pxb));
            r_sy <= SW'(32'(r_pyr) + 32'(r_pyg) + 32'(r_pyb));
            r_sz <= SW'(32'(r_pzr) + 32'(r_pzg) + 32'(r_pzb));

            // quotient estimate, low by at most one
            r_xx <= XW'(r_sx) * 4'd10;
            r_xz <= XW'(r_sz) * 4'd10;
            r_xy <= r_sy;
            r_qx <= VW'(n_px >> s2l_pkg::SH_XZ);
            r_qz <= VW'(n_pz >> s2l_pkg::SH_XZ);
            r_qy <= VW'(n_py >> s2l_pkg::SH_Y);

            r_x <= (n_rx >= 34'(s2l_pkg::DIV_X)) ? r_qx + 1'b1 : r_qx;
            r_z <= (n_rz >= 34'(s2l_pkg::DIV_Z)) ? r_qz + 1'b1 : r_qz;
            r_y <= (n_ry >= 32'(s2l_pkg::DIV_Y)) ? r_qy + 1'b1 : r_qy;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

`default_nettype wire

FILE: rtl/s2l_curve.sv
// ----------------------------------------------------------------------------
// s2l_curve
// CIELAB f() curve: linear segment or a bit-serial pipelined cube root,
// one result bit per stage, nineteen stages in all.
// ----------------------------------------------------------------------------
`default_nettype none

module s2l_curve (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic [s2l_pkg::V_W-1:0]   i_v,
    output logic [s2l_pkg::F_W-1:0]        o_f
);

    localparam int VW = s2l_pkg::V_W;
    localparam int FW = s2l_pkg::F_W;
    localparam int NB = FW;
    localparam int W2 = 35;
    localparam int W3 = 54;

    logic [VW-1:0] r_va;
    logic          r_cube_a;
    logic [22:0]   r_p;
    logic [46:0]   n_pk;

    logic [VW-1:0] r_v    [0:NB];
    logic          r_cube [0:NB];
    logic [FW-1:0] r_lin  [0:NB];
    logic [FW-1:0] r_w    [0:NB];
    logic [W2-1:0] r_w2   [0:NB];
    logic [W3-1:0] r_w3   [0:NB];

    assign n_pk = 47'(r_p) * 47'(s2l_pkg::RCP_K);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_va     <= i_v;
            r_cube_a <= i_v > s2l_pkg::CUBE_MIN;
            r_p      <= 23'(i_v[9:0]) * 23'(s2l_pkg::LIN_SLOPE);

            r_v[0]    <= r_va;
            r_cube[0] <= r_cube_a;
            r_lin[0]  <= FW'(n_pk >> s2l_pkg::SH_K) + s2l_pkg::LIN_OFS;
            r_w[0]    <= '0;
            r_w2[0]   <= '0;
            r_w3[0]   <= '0;
        end
    end

    for (genvar gi = 0; gi < NB; gi++) begin : g_root
        localparam int K = NB - 1 - gi;

        logic [W3-1:0] t1, t2, cand, target;
        logic          keep;

        always_comb begin
            t1     = W3'(r_w[gi]) << (2 * K);
            t2     = W3'(r_w2[gi]) << K;
            cand   = r_w3[gi] + t2 + (t2 << 1) + t1 + (t1 << 1) + (W3'(1) << (3 * K));
            target = W3'({r_v[gi], 32'b0});
            keep   = cand <= target;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v[gi+1]    <= r_v[gi];
                r_cube[gi+1] <= r_cube[gi];
                r_lin[gi+1]  <= r_lin[gi];
                if (keep) begin
                    r_w[gi+1]  <= r_w[gi] | (FW'(1) << K);
                    r_w2[gi+1] <= r_w2[gi] + (W2'(r_w[gi]) << (K + 1)) + (W2'(1) << (2 * K));
                    r_w3[gi+1] <= cand;
                end else begin
                    r_w[gi+1]  <= r_w[gi];
                    r_w2[gi+1] <= r_w2[gi];
                    r_w3[gi+1] <= r_w3[gi];
                end
            end
        end
    end

    assign o_f = r_cube[NB] ? r_w[NB] : r_lin[NB];

endmodule

`default_nettype wire
